// ----- hw/rtl/ppq_pkg.sv -----
// Shared types and constants for the priority process queue.
`timescale 1ns / 1ps

package ppq_pkg;

   localparam int ID_BITS       = 5;
   localparam int IN_PRIO_BITS  = 8;
   localparam int COUNT_BITS    = 6;

   // Operation codes carried in the kind field of a request.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]              kind;
      logic [ID_BITS-1:0]      entry_id;
      logic [IN_PRIO_BITS-1:0] entry_priority;
   } ppq_req_type;

   typedef struct packed {
      logic                    ok;
      logic [ID_BITS-1:0]      removed_id;
      logic                    head_valid;
      logic [ID_BITS-1:0]      head_id;
      logic [IN_PRIO_BITS-1:0] head_priority;
      logic [COUNT_BITS-1:0]   entry_count;
   } ppq_rsp_type;

   // Status handed from the sequencer to the response stage.
   typedef struct packed {
      logic                    done;
      logic                    ok;
      logic [ID_BITS-1:0]      removed_id;
      logic                    head_valid;
      logic [ID_BITS-1:0]      head_id;
      logic [IN_PRIO_BITS-1:0] head_priority;
      logic [COUNT_BITS-1:0]   entry_count;
   } ppq_status_type;

endpackage

// ----- hw/rtl/ppq_slot_ram.sv -----
// Slot memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ppq_slot_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ppq_sequencer.sv -----
// Sequencer that scans and shifts the slot memory one entry at a time.
`timescale 1ns / 1ps

module ppq_sequencer #(
   parameter int QUEUE_DEPTH   = 32,
   parameter int PRIORITY_BITS = 8,
   localparam int AW = $clog2(QUEUE_DEPTH),
   localparam int CW = $clog2(QUEUE_DEPTH + 1),
   localparam int WW = ppq_pkg::ID_BITS + PRIORITY_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ppq_pkg::ppq_req_type   req,
   output logic                   busy,
   output ppq_pkg::ppq_status_type status,
   output logic                   ram_wr_en,
   output logic [AW-1:0]          ram_wr_addr,
   output logic [WW-1:0]          ram_wr_data,
   output logic [AW-1:0]          ram_rd_addr,
   input  logic [WW-1:0]          ram_rd_data
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_READ    = 6'b000010,
      ST_EVAL    = 6'b000100,
      ST_PLACE   = 6'b001000,
      ST_HEAD_RD = 6'b010000,
      ST_HEAD_EV = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   logic [CW-1:0]                  occ_ff, occ_in;
   logic [1:0]                     kind_ff, kind_in;
   logic [ppq_pkg::ID_BITS-1:0]    id_ff, id_in;
   logic [PRIORITY_BITS-1:0]       prio_ff, prio_in;
   logic                           found_ff, found_in;
   logic                           ok_ff, ok_in;
   logic [ppq_pkg::ID_BITS-1:0]    removed_ff, removed_in;

   logic                           accept;
   logic [CW-1:0]                  idx_m1, idx_p1;
   logic [ppq_pkg::ID_BITS-1:0]    rd_id;
   logic [PRIORITY_BITS-1:0]       rd_prio;
   logic                           match;
   logic [PRIORITY_BITS+ppq_pkg::IN_PRIO_BITS-1:0] prio_wide_in;
   logic [PRIORITY_BITS+ppq_pkg::IN_PRIO_BITS-1:0] prio_wide_out;
   logic [CW+ppq_pkg::COUNT_BITS-1:0]              count_wide;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign idx_m1  = idx_ff - CW'(1);
   assign idx_p1  = idx_ff + CW'(1);
   assign rd_id   = ram_rd_data[WW-1 -: ppq_pkg::ID_BITS];
   assign rd_prio = ram_rd_data[PRIORITY_BITS-1:0];
   assign match   = !found_ff && ((kind_ff == ppq_pkg::KIND_POP) || (rd_id == id_ff));

   // Only the low PRIORITY_BITS of the request priority are stored.
   assign prio_wide_in  = {{PRIORITY_BITS{1'b0}}, req.entry_priority};
   assign prio_wide_out = {{ppq_pkg::IN_PRIO_BITS{1'b0}}, rd_prio};
   assign count_wide    = {{ppq_pkg::COUNT_BITS{1'b0}}, occ_ff};

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      occ_in      = occ_ff;
      kind_in     = kind_ff;
      id_in       = id_ff;
      prio_in     = prio_ff;
      found_in    = found_ff;
      ok_in       = ok_ff;
      removed_in  = removed_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[AW-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_addr = idx_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in    = req.kind;
               id_in      = req.entry_id;
               prio_in    = prio_wide_in[PRIORITY_BITS-1:0];
               found_in   = 1'b0;
               ok_in      = 1'b0;
               removed_in = '0;
               priority if (req.kind == ppq_pkg::KIND_INSERT) begin
                  if (occ_ff == CW'(QUEUE_DEPTH)) begin
                     state_in = ST_HEAD_RD;
                  end else if (occ_ff == '0) begin
                     idx_in   = '0;
                     state_in = ST_PLACE;
                  end else begin
                     idx_in   = occ_ff;
                     state_in = ST_READ;
                  end
               end else if (req.kind == ppq_pkg::KIND_POP ||
                            req.kind == ppq_pkg::KIND_REMOVE) begin
                  if (occ_ff == '0) begin
                     state_in = ST_HEAD_RD;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_READ;
                  end
               end else begin
                  state_in = ST_HEAD_RD;
               end
            end
         end
         ST_READ: begin
            // Insert walks from the tail towards the head; pop and remove
            // walk from the head towards the tail.
            if (kind_ff == ppq_pkg::KIND_INSERT) begin
               ram_rd_addr = idx_m1[AW-1:0];
            end
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (kind_ff == ppq_pkg::KIND_INSERT) begin
               if (rd_prio >= prio_ff) begin
                  state_in = ST_PLACE;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_ff[AW-1:0];
                  idx_in      = idx_m1;
                  state_in    = (idx_m1 == '0) ? ST_PLACE : ST_READ;
               end
            end else begin
               if (match) begin
                  found_in   = 1'b1;
                  removed_in = rd_id;
               end
               if (found_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_m1[AW-1:0];
               end
               idx_in = idx_p1;
               if (idx_p1 == occ_ff) begin
                  if (found_ff || match) begin
                     occ_in = occ_ff - CW'(1);
                     ok_in  = 1'b1;
                  end
                  state_in = ST_HEAD_RD;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {id_ff, prio_ff};
            occ_in      = occ_ff + CW'(1);
            ok_in       = 1'b1;
            state_in    = ST_HEAD_RD;
         end
         ST_HEAD_RD: begin
            ram_rd_addr = '0;
            state_in    = ST_HEAD_EV;
         end
         ST_HEAD_EV: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
      idx_ff     <= idx_in;
      kind_ff    <= kind_in;
      id_ff      <= id_in;
      prio_ff    <= prio_in;
      found_ff   <= found_in;
      ok_ff      <= ok_in;
      removed_ff <= removed_in;
   end

   always_comb begin
      status.done          = (state_ff == ST_HEAD_EV);
      status.ok            = ok_ff;
      status.removed_id    = removed_ff;
      status.head_valid    = (occ_ff != '0);
      status.head_id       = rd_id;
      status.head_priority = prio_wide_out[ppq_pkg::IN_PRIO_BITS-1:0];
      status.entry_count   = count_wide[ppq_pkg::COUNT_BITS-1:0];
   end

endmodule

// ----- hw/rtl/priority_process_queue.sv -----
// Top level of the priority process queue: slot memory, sequencer and result register.
`timescale 1ns / 1ps

// Channel   Ports                    Direction  Handshake
// request   start, busy, req_item    in         taken when start is high and busy is low
// result    rsp_strobe, rsp_item     out        shown for one cycle, cannot be held off
//
// Each item is worked through the single read port of the slot memory: every entry
// visited takes a read step and an evaluate step. An insert walks from the tail until
// it finds its place, a pop or remove walks every occupied slot, and a refused or
// unused operation only rereads the head. No new item is taken while busy is high.
// The result is strobed in the cycle after the sequencer finishes; busy is already
// low then, so the next item may be accepted in that same cycle.
// Synchronous reset empties the queue at once; the slot contents need no clearing.
// The receiver cannot stall, so busy depends on the sequencer alone.

module priority_process_queue #(
   parameter int QUEUE_DEPTH   = 32,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ppq_pkg::ppq_req_type req_item,
   output logic                 rsp_strobe,
   output ppq_pkg::ppq_rsp_type rsp_item
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int WW = ppq_pkg::ID_BITS + PRIORITY_BITS;

   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [WW-1:0]           ram_wr_data;
   logic [AW-1:0]           ram_rd_addr;
   logic [WW-1:0]           ram_rd_data;
   ppq_pkg::ppq_status_type status;

   logic                    rsp_strobe_ff;
   ppq_pkg::ppq_rsp_type    rsp_item_ff, rsp_item_in;

   // The slots hold identifier and priority side by side, slot zero being the head.
   ppq_slot_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (WW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ppq_sequencer #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req_item),
      .busy        (busy),
      .status      (status),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // When the queue is empty the head fields report zero rather than whatever
   // stale entry still sits in slot zero.
   always_comb begin
      rsp_item_in.ok          = status.ok;
      rsp_item_in.removed_id  = status.removed_id;
      rsp_item_in.head_valid  = status.head_valid;
      rsp_item_in.entry_count = status.entry_count;
      if (status.head_valid) begin
         rsp_item_in.head_id       = status.head_id;
         rsp_item_in.head_priority = status.head_priority;
      end else begin
         rsp_item_in.head_id       = '0;
         rsp_item_in.head_priority = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= status.done;
      end
      if (status.done) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
